FILE: hw/rtl/lcd_scanline_timing_core_assert.svh
`ifndef LCD_SCANLINE_TIMING_CORE_ASSERT_SVH
`define LCD_SCANLINE_TIMING_CORE_ASSERT_SVH

// same-cycle implication, sampled at clk, quiet during reset
`define LCDST_ASSERT_HOLDS(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, sampled at clk, quiet during reset
`define LCDST_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: hw/rtl/lcdst_pkg.sv
`timescale 1ns / 1ps

package lcdst_pkg;

	localparam int VISIBLE_CYCLES = 1008;
	localparam int HBLANK_CYCLES  = 224;
	localparam int VISIBLE_LINES  = 160;
	localparam int TOTAL_LINES    = 228;

	localparam int TICK_W = 7;
	localparam int ACC_W  = 11;
	localparam int LINE_W = 8;
	localparam int DATA_W = 8;

	// register indexes of the configuration port
	typedef enum logic [1:0] {
		CFG_VCOUNT_TARGET = 2'd0,
		CFG_HBLANK_IRQ_EN = 2'd1,
		CFG_VBLANK_IRQ_EN = 2'd2,
		CFG_VCOUNT_IRQ_EN = 2'd3
	} cfg_idx_t;

	typedef enum logic [3:0] {
		PH_VISIBLE  = 4'b0001,
		PH_HBLANK   = 4'b0010,
		PH_VBLANK   = 4'b0100,
		PH_VBHBLANK = 4'b1000
	} phase_t;

	typedef struct packed {
		logic [LINE_W-1:0] vcount_target;
		logic              hblank_irq_en;
		logic              vblank_irq_en;
		logic              vcount_irq_en;
	} cfg_t;

	typedef struct packed {
		phase_t            phase;
		logic [ACC_W-1:0]  acc;
		logic [LINE_W-1:0] line;
		logic              hblank_st;
		logic              vblank_st;
		logic              vcount_st;
		logic              hblank_dma;
		logic              vblank_dma;
	} state_t;

	typedef struct packed {
		logic [LINE_W-1:0] vcount;
		logic              hblank_flag;
		logic              vblank_flag;
		logic              vcount_match_flag;
		logic              irq_hblank;
		logic              irq_vblank;
		logic              irq_vcount;
		logic              hblank_dma_window;
		logic              vblank_dma_window;
		logic              render_line;
		logic              frame_start_vblank;
	} res_t;

endpackage

FILE: hw/rtl/lcdst_if.sv
`timescale 1ns / 1ps

interface lcdst_tick_if import lcdst_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [TICK_W-1:0] elapsed_ticks;

	modport source (output valid, output elapsed_ticks, input ready);
	modport sink (input valid, input elapsed_ticks, output ready);
endinterface

interface lcdst_timing_if import lcdst_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [LINE_W-1:0] vcount;
	logic              hblank_flag;
	logic              vblank_flag;
	logic              vcount_match_flag;
	logic              irq_hblank;
	logic              irq_vblank;
	logic              irq_vcount;
	logic              hblank_dma_window;
	logic              vblank_dma_window;
	logic              render_line;
	logic              frame_start_vblank;

	modport source (output valid, input ready, output vcount, output hblank_flag,
		output vblank_flag, output vcount_match_flag, output irq_hblank,
		output irq_vblank, output irq_vcount, output hblank_dma_window,
		output vblank_dma_window, output render_line, output frame_start_vblank);
	modport sink (input valid, output ready, input vcount, input hblank_flag,
		input vblank_flag, input vcount_match_flag, input irq_hblank,
		input irq_vblank, input irq_vcount, input hblank_dma_window,
		input vblank_dma_window, input render_line, input frame_start_vblank);
endinterface

interface lcdst_cfg_if import lcdst_pkg::*; ();
	logic              valid;
	logic              ready;
	cfg_idx_t          idx;
	logic [DATA_W-1:0] data;

	modport source (output valid, output idx, output data, input ready);
	modport sink (input valid, input idx, input data, output ready);
endinterface

FILE: hw/rtl/lcdst_cfg.sv
`timescale 1ns / 1ps

module lcdst_cfg import lcdst_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	lcdst_cfg_if.sink cfg,
	output cfg_t regs
);

	cfg_t regs_q;

	assign cfg.ready = 1'b1;
	assign regs      = regs_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q <= '0;
		end else if (cfg.valid) begin
			unique case (cfg.idx)
				CFG_VCOUNT_TARGET: begin
					regs_q.vcount_target <= cfg.data[LINE_W-1:0];
				end
				CFG_HBLANK_IRQ_EN: begin
					regs_q.hblank_irq_en <= cfg.data[0];
				end
				CFG_VBLANK_IRQ_EN: begin
					regs_q.vblank_irq_en <= cfg.data[0];
				end
				CFG_VCOUNT_IRQ_EN: begin
					regs_q.vcount_irq_en <= cfg.data[0];
				end
				default: begin
					regs_q <= regs_q;
				end
			endcase
		end
	end

endmodule

FILE: hw/rtl/lcdst_step.sv
`timescale 1ns / 1ps

module lcdst_step import lcdst_pkg::*; (
	input  state_t            cur,
	input  cfg_t              regs,
	input  logic [TICK_W-1:0] ticks,
	output state_t            nxt,
	output res_t              res
);

	logic [ACC_W-1:0]  acc_sum;
	logic [LINE_W-1:0] line_inc;
	logic              match;
	logic              irq_h;
	logic              irq_v;
	logic              irq_c;
	logic              render;
	logic              frame;

	assign acc_sum  = cur.acc + ACC_W'(ticks);
	// next line with wrap at the bottom of the frame
	assign line_inc = (cur.line == LINE_W'(TOTAL_LINES - 1)) ? '0 : cur.line + LINE_W'(1);
	assign match    = (line_inc == regs.vcount_target);

	always_comb begin
		nxt     = cur;
		nxt.acc = acc_sum;
		irq_h   = 1'b0;
		irq_v   = 1'b0;
		irq_c   = 1'b0;
		render  = 1'b0;
		frame   = 1'b0;
		unique case (cur.phase)
			PH_VISIBLE: begin
				if (acc_sum >= ACC_W'(VISIBLE_CYCLES)) begin
					nxt.acc        = acc_sum - ACC_W'(VISIBLE_CYCLES);
					nxt.phase      = PH_HBLANK;
					nxt.hblank_st  = 1'b1;
					nxt.hblank_dma = 1'b1;
					irq_h          = regs.hblank_irq_en;
					render         = 1'b1;
				end
			end
			PH_HBLANK: begin
				if (acc_sum >= ACC_W'(HBLANK_CYCLES)) begin
					nxt.acc        = acc_sum - ACC_W'(HBLANK_CYCLES);
					nxt.line       = line_inc;
					nxt.vcount_st  = match;
					irq_c          = match & regs.vcount_irq_en;
					nxt.hblank_st  = 1'b0;
					nxt.hblank_dma = 1'b0;
					if (line_inc < LINE_W'(VISIBLE_LINES)) begin
						nxt.phase = PH_VISIBLE;
					end else begin
						nxt.phase      = PH_VBLANK;
						frame          = 1'b1;
						nxt.vblank_st  = 1'b1;
						nxt.vblank_dma = 1'b1;
						irq_v          = regs.vblank_irq_en;
					end
				end
			end
			PH_VBLANK: begin
				if (acc_sum >= ACC_W'(VISIBLE_CYCLES)) begin
					nxt.acc       = acc_sum - ACC_W'(VISIBLE_CYCLES);
					nxt.phase     = PH_VBHBLANK;
					nxt.hblank_st = 1'b1;
					irq_h         = regs.hblank_irq_en;
				end
			end
			PH_VBHBLANK: begin
				if (acc_sum >= ACC_W'(HBLANK_CYCLES)) begin
					nxt.acc        = acc_sum - ACC_W'(HBLANK_CYCLES);
					nxt.line       = line_inc;
					nxt.vcount_st  = match;
					irq_c          = match & regs.vcount_irq_en;
					nxt.hblank_st  = 1'b0;
					nxt.hblank_dma = 1'b0;
					if (line_inc == '0) begin
						nxt.phase      = PH_VISIBLE;
						nxt.vblank_st  = 1'b0;
						nxt.vblank_dma = 1'b0;
					end else begin
						nxt.phase = PH_VBLANK;
						// vblank flag drops one line early
						if (line_inc == LINE_W'(TOTAL_LINES - 1)) begin
							nxt.vblank_st = 1'b0;
						end
					end
				end
			end
			default: begin
				nxt = cur;
			end
		endcase
	end

	always_comb begin
		res.vcount             = nxt.line;
		res.hblank_flag        = nxt.hblank_st;
		res.vblank_flag        = nxt.vblank_st;
		res.vcount_match_flag  = nxt.vcount_st;
		res.irq_hblank         = irq_h;
		res.irq_vblank         = irq_v;
		res.irq_vcount         = irq_c;
		res.hblank_dma_window  = nxt.hblank_dma;
		res.vblank_dma_window  = nxt.vblank_dma;
		res.render_line        = render;
		res.frame_start_vblank = frame;
	end

endmodule

FILE: hw/rtl/lcd_scanline_timing_core.sv
`timescale 1ns / 1ps

// lcd scanline timing generator
// ticks channel: each beat carries elapsed_ticks, the cpu cycles since the last beat
// timing channel: one beat per ticks beat, in order, with the line number, status
//   flags, irq pulses, dma window levels and the render / frame-start pulses as
//   they stand after that beat's cycles are counted
// cfg channel: always ready; idx selects vcount target or one of the three irq
//   enables, data carries the value; write only while no ticks beat is in flight
// path: a ticks beat is held in the input register, then its step result in the result register
// throughput: one beat per cycle while the result register is not stalled; the accumulator,
//   line counter and phase loop back through one step unit
// stall: a full result register with timing.ready low holds its beat; the input
//   register still takes one more beat, then ticks.ready drops until the
//   result is taken
// reset: phase visible, accumulator, line, flags, dma levels and all config
//   registers cleared; both register stages empty

module lcd_scanline_timing_core import lcdst_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	lcdst_tick_if.sink     ticks,
	lcdst_timing_if.source timing,
	lcdst_cfg_if.sink      cfg
);

	// input stage
	logic [TICK_W-1:0] ticks_s1;
	logic              valid_s1;

	// result stage
	res_t res_s2;
	logic valid_s2;

	// timing state
	state_t state_q;
	state_t state_nxt;
	res_t   res_nxt;
	cfg_t   regs;

	logic adv;

	lcdst_cfg u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.regs   (regs)
	);

	lcdst_step u_step (
		.cur   (state_q),
		.regs  (regs),
		.ticks (ticks_s1),
		.nxt   (state_nxt),
		.res   (res_nxt)
	);

	// move the input stage on when the result register is free or draining
	assign adv         = valid_s1 & (~valid_s2 | timing.ready);
	assign ticks.ready = ~valid_s1 | adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (ticks.ready) begin
			valid_s1 <= ticks.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (ticks.valid && ticks.ready) begin
			ticks_s1 <= ticks.elapsed_ticks;
		end
	end

	// state only moves when a beat goes into the result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.phase      <= PH_VISIBLE;
			state_q.acc        <= '0;
			state_q.line       <= '0;
			state_q.hblank_st  <= 1'b0;
			state_q.vblank_st  <= 1'b0;
			state_q.vcount_st  <= 1'b0;
			state_q.hblank_dma <= 1'b0;
			state_q.vblank_dma <= 1'b0;
		end else if (adv) begin
			state_q <= state_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s2 <= 1'b1;
		end else if (timing.ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			res_s2 <= res_nxt;
		end
	end

	assign timing.valid              = valid_s2;
	assign timing.vcount             = res_s2.vcount;
	assign timing.hblank_flag        = res_s2.hblank_flag;
	assign timing.vblank_flag        = res_s2.vblank_flag;
	assign timing.vcount_match_flag  = res_s2.vcount_match_flag;
	assign timing.irq_hblank         = res_s2.irq_hblank;
	assign timing.irq_vblank         = res_s2.irq_vblank;
	assign timing.irq_vcount         = res_s2.irq_vcount;
	assign timing.hblank_dma_window  = res_s2.hblank_dma_window;
	assign timing.vblank_dma_window  = res_s2.vblank_dma_window;
	assign timing.render_line        = res_s2.render_line;
	assign timing.frame_start_vblank = res_s2.frame_start_vblank;

endmodule

FILE: hw/rtl/lcdst_checker.sv
`timescale 1ns / 1ps

`include "lcd_scanline_timing_core_assert.svh"

module lcdst_checker import lcdst_pkg::*; (
	input logic              clk,
	input logic              arst_n,
	input logic              out_valid,
	input logic              out_ready,
	input logic [LINE_W-1:0] vcount,
	input logic              hblank_flag,
	input logic              vblank_flag,
	input logic              irq_hblank,
	input logic              hblank_dma_window,
	input logic              vblank_dma_window,
	input logic              render_line,
	input logic              frame_start_vblank
);

	`LCDST_ASSERT_HOLDS(a_line_range, out_valid, vcount <= LINE_W'(TOTAL_LINES - 1), "vcount past last line")

	`LCDST_ASSERT_HOLDS(a_render_in_hblank, out_valid && render_line, hblank_flag && hblank_dma_window, "render pulse outside visible hblank")

	`LCDST_ASSERT_HOLDS(a_hirq_flag, out_valid && irq_hblank, hblank_flag, "hblank irq without hblank flag")

	`LCDST_ASSERT_HOLDS(a_frame_entry, out_valid && frame_start_vblank, vblank_flag && vblank_dma_window && !hblank_flag, "frame start without vblank entry")

	`LCDST_ASSERT_NEXT(a_stall_hold, out_valid && !out_ready, out_valid && $stable(vcount) && $stable(render_line), "stalled result beat changed")

endmodule

bind lcd_scanline_timing_core lcdst_checker u_lcdst_checker (
	.clk                (clk),
	.arst_n             (arst_n),
	.out_valid          (timing.valid),
	.out_ready          (timing.ready),
	.vcount             (timing.vcount),
	.hblank_flag        (timing.hblank_flag),
	.vblank_flag        (timing.vblank_flag),
	.irq_hblank         (timing.irq_hblank),
	.hblank_dma_window  (timing.hblank_dma_window),
	.vblank_dma_window  (timing.vblank_dma_window),
	.render_line        (timing.render_line),
	.frame_start_vblank (timing.frame_start_vblank)
);
